// File: rtl/core/dpas_pkg.sv
// Shared types, codes and widths for the data-processing ALU and shifter.
`timescale 1ns / 1ps
package dpas_pkg;

    localparam int DATA_W      = 32;
    localparam int NUM_REGS    = 16;
    localparam int REG_IDX_W   = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // command field
    localparam logic [1:0] CMD_DP  = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_MLA = 2'd2;

    // ALU opcodes
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ORR = 4'd5;
    localparam logic [3:0] OP_MOV = 4'd6;
    localparam logic [3:0] OP_TST = 4'd7;
    localparam logic [3:0] OP_TEQ = 4'd8;
    localparam logic [3:0] OP_CMP = 4'd9;

    // shifter kinds
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // decoded instruction class
    localparam logic [1:0] K_NOP = 2'd0;
    localparam logic [1:0] K_ALU = 2'd1;
    localparam logic [1:0] K_MUL = 2'd2;
    localparam logic [1:0] K_MLA = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [3:0]           alu_op;
        logic                 writes_rd;
        logic                 set_flags;
        logic                 is_imm;
        logic [REG_IDX_W-1:0] rn;
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] rm;
        logic [REG_IDX_W-1:0] rs;
        logic [7:0]           imm8;
        logic [3:0]           rot_half;
        logic [1:0]           shift_kind;
        logic [4:0]           shift_dist;
    } t_uop;

endpackage

// File: rtl/core/dpas_front.sv
// Front end: unpacks an input word and classifies the instruction.
`timescale 1ns / 1ps
module dpas_front
    import dpas_pkg::*;
(
    input  logic [IN_TDATA_W-1:0] i_tdata,
    output t_uop                  o_uop
);

    logic [1:0] cmd;
    logic [3:0] opcode;
    logic       is_alu;
    logic       is_test;

    always_comb begin
        cmd     = i_tdata[1:0];
        opcode  = i_tdata[5:2];
        is_alu  = (cmd == CMD_DP) && (opcode <= OP_CMP);
        is_test = opcode inside {OP_TST, OP_TEQ, OP_CMP};

        o_uop.alu_op     = opcode;
        o_uop.set_flags  = i_tdata[6];
        o_uop.is_imm     = i_tdata[7];
        o_uop.rn         = i_tdata[11:8];
        o_uop.rd         = i_tdata[15:12];
        o_uop.rm         = i_tdata[19:16];
        o_uop.rs         = i_tdata[23:20];
        o_uop.imm8       = i_tdata[31:24];
        o_uop.rot_half   = i_tdata[35:32];
        o_uop.shift_kind = i_tdata[37:36];
        o_uop.shift_dist = i_tdata[42:38];

        case (cmd)
            CMD_DP:  o_uop.kind = is_alu ? K_ALU : K_NOP;
            CMD_MUL: o_uop.kind = K_MUL;
            CMD_MLA: o_uop.kind = K_MLA;
            default: o_uop.kind = K_NOP;
        endcase

        o_uop.writes_rd = (is_alu && !is_test) || (cmd == CMD_MUL) || (cmd == CMD_MLA);
    end

endmodule

// File: rtl/core/dpas_queue.sv
// Short queue of decoded instructions between front and back ends.
`timescale 1ns / 1ps
module dpas_queue
    import dpas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_uop i_uop,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_uop o_uop
);

    t_uop                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_uop   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_uop;
        end
    end

endmodule

// File: rtl/core/dpas_back.sv
// Back end: register file read, shifter, ALU/multiplier, flags and output word.
`timescale 1ns / 1ps
module dpas_back
    import dpas_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_uop_valid,
    input  t_uop                   i_uop,
    output logic                   o_uop_pop,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    // two copies of the register file give three read ports
    logic [DATA_W-1:0]    r_mem_a [NUM_REGS];
    logic [DATA_W-1:0]    r_mem_b [NUM_REGS];
    logic [NUM_REGS-1:0]  r_reg_valid;

    logic                 r_stage_valid;
    t_uop                 r_stage_uop;
    logic [DATA_W-1:0]    r_rn_data;
    logic [DATA_W-1:0]    r_rm_data;
    logic [DATA_W-1:0]    r_rs_data;

    logic                 r_fwd_valid;
    logic [REG_IDX_W-1:0] r_fwd_idx;
    logic [DATA_W-1:0]    r_fwd_data;

    logic                 r_flag_n;
    logic                 r_flag_z;
    logic                 r_flag_c;

    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    logic                 exec_fire;
    logic                 stage_load;

    logic [DATA_W-1:0]    op_a;
    logic [DATA_W-1:0]    op_m;
    logic [DATA_W-1:0]    op_s;
    logic [DATA_W-1:0]    op_b;
    logic                 sh_c;
    logic [4:0]           rot_amt;
    logic [4:0]           sam;
    logic [4:0]           lsl_idx;
    logic [DATA_W-1:0]    imm_ext;
    logic [2*DATA_W-1:0]  imm_dbl;
    logic [2*DATA_W-1:0]  rm_dbl;
    logic [DATA_W-1:0]    mul_prod;
    logic [DATA_W-1:0]    result;
    logic                 n_flag_n;
    logic                 n_flag_z;
    logic                 n_flag_c;
    logic                 written;

    assign exec_fire  = r_stage_valid && (!r_out_valid || i_tready);
    assign stage_load = !r_stage_valid || exec_fire;
    assign o_uop_pop  = stage_load && i_uop_valid;
    assign o_tvalid   = r_out_valid;
    assign o_tdata    = r_out_data;

    // operands with bypass of the write that landed with the read
    always_comb begin
        op_a = (r_fwd_valid && r_fwd_idx == r_stage_uop.rn) ? r_fwd_data : r_rn_data;
        op_m = (r_fwd_valid && r_fwd_idx == r_stage_uop.rm) ? r_fwd_data : r_rm_data;
        op_s = (r_fwd_valid && r_fwd_idx == r_stage_uop.rs) ? r_fwd_data : r_rs_data;
    end

    // operand2: rotated immediate or barrel shifter
    always_comb begin
        rot_amt = {r_stage_uop.rot_half, 1'b0};
        sam     = r_stage_uop.shift_dist;
        lsl_idx = 5'd0 - sam;
        imm_ext = {{(DATA_W-8){1'b0}}, r_stage_uop.imm8};
        imm_dbl = {imm_ext, imm_ext} >> rot_amt;
        rm_dbl  = {op_m, op_m} >> sam;
        op_b    = op_m;
        sh_c    = r_flag_c;
        if (r_stage_uop.is_imm) begin
            op_b = imm_dbl[DATA_W-1:0];
            if (rot_amt != 5'd0) begin
                sh_c = op_b[DATA_W-1];
            end
        end else if (sam != 5'd0) begin
            case (r_stage_uop.shift_kind)
                SH_LSL: begin
                    op_b = op_m << sam;
                    sh_c = op_m[lsl_idx];
                end
                SH_LSR: begin
                    op_b = op_m >> sam;
                    sh_c = op_m[sam - 5'd1];
                end
                SH_ASR: begin
                    op_b = DATA_W'($signed(op_m) >>> sam);
                    sh_c = op_m[sam - 5'd1];
                end
                default: begin
                    op_b = rm_dbl[DATA_W-1:0];
                    sh_c = op_m[sam - 5'd1];
                end
            endcase
        end
    end

    // execute
    always_comb begin
        mul_prod = DATA_W'(op_m * op_s);
        result   = '0;
        n_flag_n = r_flag_n;
        n_flag_z = r_flag_z;
        n_flag_c = r_flag_c;
        written  = r_stage_uop.writes_rd;
        case (r_stage_uop.kind)
            K_ALU: begin
                n_flag_c = sh_c;
                case (r_stage_uop.alu_op)
                    OP_AND, OP_TST: result = op_a & op_b;
                    OP_EOR, OP_TEQ: result = op_a ^ op_b;
                    OP_ORR:         result = op_a | op_b;
                    OP_MOV:         result = op_b;
                    OP_ADD: begin
                        result   = op_a + op_b;
                        n_flag_c = (result < op_a);
                    end
                    OP_RSB: begin
                        result   = op_b - op_a;
                        n_flag_c = (op_b >= op_a);
                    end
                    default: begin
                        result   = op_a - op_b;
                        n_flag_c = (op_a >= op_b);
                    end
                endcase
                if (r_stage_uop.set_flags) begin
                    n_flag_n = result[DATA_W-1];
                    n_flag_z = (result == '0);
                end else begin
                    n_flag_c = r_flag_c;
                end
            end
            K_MUL, K_MLA: begin
                result = (r_stage_uop.kind == K_MLA) ? mul_prod + op_a : mul_prod;
                if (r_stage_uop.set_flags) begin
                    n_flag_n = result[DATA_W-1];
                    n_flag_z = (result == '0);
                end
            end
            default: begin
                result  = '0;
                written = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_valid   <= '0;
            r_stage_valid <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_flag_n      <= 1'b0;
            r_flag_z      <= 1'b0;
            r_flag_c      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (stage_load) begin
                r_stage_valid <= i_uop_valid;
                r_fwd_valid   <= exec_fire && written;
            end
            if (exec_fire) begin
                if (written) begin
                    r_reg_valid[r_stage_uop.rd] <= 1'b1;
                end
                r_flag_n    <= n_flag_n;
                r_flag_z    <= n_flag_z;
                r_flag_c    <= n_flag_c;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire && written) begin
            r_mem_a[r_stage_uop.rd] <= result;
            r_mem_b[r_stage_uop.rd] <= result;
        end
        if (stage_load) begin
            r_stage_uop <= i_uop;
            r_rn_data   <= r_reg_valid[i_uop.rn] ? r_mem_a[i_uop.rn] : '0;
            r_rm_data   <= r_reg_valid[i_uop.rm] ? r_mem_a[i_uop.rm] : '0;
            r_rs_data   <= r_reg_valid[i_uop.rs] ? r_mem_b[i_uop.rs] : '0;
            r_fwd_idx   <= r_stage_uop.rd;
            r_fwd_data  <= result;
        end
        if (exec_fire) begin
            r_out_data <= {n_flag_c, n_flag_z, n_flag_n, r_stage_uop.rd, written, result};
        end
    end

endmodule

// File: rtl/core/data_processing_alu_shifter.sv
// An accepted word passes the decode queue, execute stage and output register to m_axis.
// Throughput: one instruction per cycle while m_axis_tready is high; the register file
// bypass and flag registers let each instruction use the results of the one just before it.
// A four-entry decode queue decouples s_axis from the execute stage and the output register.
// Reset: i_rst_n synchronous, active low; clears the queue, the pipeline valids, the flags
// and the register valid bits, so every register reads as zero until written.
`timescale 1ns / 1ps
module data_processing_alu_shifter
    import dpas_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cmd, opcode, set_flags, is_imm, rn_index, rd_index, rm_index, rs_index,
    // imm8, rotate_half, shift_kind, shift_dist, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_value, reg_written, dest_index, flag_n, flag_z, flag_c
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_uop front_uop;
    t_uop queue_uop;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic push;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    dpas_front u_front (
        .i_tdata (s_axis_tdata),
        .o_uop   (front_uop)
    );

    dpas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_uop   (front_uop),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_uop   (queue_uop)
    );

    dpas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (queue_valid),
        .i_uop       (queue_uop),
        .o_uop_pop   (queue_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule
